// File: src/tcjq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjq_pkg
// shared types and constants of the two-class job queue: command and
// response words, mode codes, controller to datapath command/status
// ----------------------------------------------------------------------------
package tcjq_pkg;

	localparam int ID_FIELD_W = 16;
	localparam int PAGE_W     = 16;
	localparam int MODE_W     = 3;

	// command modes
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PROCESS  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CANCEL   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIST_FWD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIST_REV = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [ID_FIELD_W-1:0] job_id;
		logic [PAGE_W-1:0]     page_count;
		logic                  urgent;
	} cmd_t;

	typedef struct packed {
		logic                  found;
		logic [ID_FIELD_W-1:0] out_id;
		logic [PAGE_W-1:0]     out_pages;
		logic                  out_urgent;
		logic                  last;
	} rsp_t;

	// which logical slot the storage read addresses
	typedef enum logic [1:0] {
		RD_FWD  = 2'd0,  // slot idx
		RD_REV  = 2'd1,  // slot count-1-idx
		RD_NEXT = 2'd2   // slot idx+1
	} rd_sel_t;

	typedef struct packed {
		logic    latch;        // capture command word, clear index
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    idx_inc;
		logic    emit_hit;     // send job from read data
		logic    emit_miss;    // send not-found word
		logic    emit_last_idx;// last flag from index, else forced
		logic    add_write;
		logic    pop_head;
		logic    shift_write;  // read data moves down to slot idx
		logic    count_dec;
	} ctl_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              count_zero;
		logic              full;
		logic              idx_end;
		logic              idx_last;
		logic              idx_zero;
		logic              match;
		logic              out_free;
	} sts_t;

endpackage

// File: src/two_class_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_job_queue
// ordered job queue with urgent jobs pushed at the head and normal jobs
// at the tail; commands add, process head, cancel by id and list
// ----------------------------------------------------------------------------
//
// channel   dir  word     handshake              notes
// cmd       in   cmd_t    cmd_valid / cmd_stall  one command per word
// rsp       out  rsp_t    rsp_valid / rsp_stall  none for an add, one or more words for other commands
//
// - one command at a time; every queue access goes through the one storage
//   memory, at most one read or write per step for scans, moves and listing
// - add: duplicate search over the queue
// - cancel: a head job is popped; for any other job,
//   the jobs behind the removed one move up one slot each
// - reset empties the queue at once
// - a stalled response holds the sequencer only at the next word it sends;
//   the next command is taken while the last word still waits
//
module two_class_job_queue import tcjq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic clk,
	input  logic arst_n,
	// command side
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	// response side
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// command and status between sequencer and datapath
	ctl_t ctl;
	sts_t sts;

	tcjq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// storage is a circular buffer so urgent adds and head removal need
	// no moves; only a cancel in the middle moves entries
	tcjq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

// File: src/tcjq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjq_dp
// job storage as a circular buffer in one memory, head/count/index
// registers, command word holding register and response register
// ----------------------------------------------------------------------------
module tcjq_dp import tcjq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  ctl_t ctl,
	output sts_t sts,
	input  logic rsp_stall,
	output rsp_t rsp,
	output logic rsp_valid
);

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
	localparam int EW   = ID_W + PAGE_W + 1;
	localparam logic [CW:0]   DEPTH_X   = (CW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	// logical position to physical slot, wrapping past the end
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] sum;
		sum = (CW+1)'(h) + (CW+1)'(i);
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	logic [EW-1:0]     mem [QUEUE_DEPTH];
	logic [EW-1:0]     rd_data_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   id_q;
	logic [PAGE_W-1:0] pages_q;
	logic              urgent_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [AW-1:0]     head_dec;
	logic [AW-1:0]     head_inc;
	logic [CW-1:0]     idx_plus1;
	logic [CW-1:0]     rd_log;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data;
	logic              wr_en;
	logic [ID_W-1:0]   rd_id;
	logic              out_free;

	assign head_dec  = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	assign idx_plus1 = idx_q + CW'(1);
	assign rd_id     = rd_data_q[EW-1 -: ID_W];
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		case (ctl.rd_sel)
			RD_FWD:  rd_log = idx_q;
			RD_REV:  rd_log = count_q - idx_q - CW'(1);
			RD_NEXT: rd_log = idx_plus1;
			default: rd_log = idx_q;
		endcase
	end
	assign rd_addr = slot(head_q, rd_log);

	always_comb begin
		wr_en   = ctl.add_write || ctl.shift_write;
		wr_data = rd_data_q;
		wr_addr = slot(head_q, idx_q);
		if (ctl.add_write) begin
			wr_data = {id_q, pages_q, urgent_q};
			wr_addr = urgent_q ? head_dec : slot(head_q, count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// command word
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			mode_q   <= cmd.mode;
			id_q     <= cmd.job_id[ID_W-1:0];
			pages_q  <= cmd.page_count;
			urgent_q <= cmd.urgent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.add_write) begin
				count_q <= count_q + CW'(1);
				if (urgent_q) begin
					head_q <= head_dec;
				end
			end else if (ctl.pop_head) begin
				count_q <= count_q - CW'(1);
				head_q  <= head_inc;
			end else if (ctl.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.latch) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_plus1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit_hit || ctl.emit_miss) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_hit) begin
			rsp_q.found      <= 1'b1;
			rsp_q.out_id     <= ID_FIELD_W'(rd_id);
			rsp_q.out_pages  <= rd_data_q[PAGE_W:1];
			rsp_q.out_urgent <= rd_data_q[0];
			rsp_q.last       <= ctl.emit_last_idx ? (idx_plus1 == count_q) : 1'b1;
		end else if (ctl.emit_miss) begin
			rsp_q <= '{found: 1'b0, out_id: '0, out_pages: '0, out_urgent: 1'b0,
				last: 1'b1};
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.mode       = mode_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.full       = (count_q == DEPTH_C);
	assign sts.idx_end    = (idx_q == count_q);
	assign sts.idx_last   = (idx_plus1 == count_q);
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.match      = (rd_id == id_q);
	assign sts.out_free   = out_free;

endmodule

// File: src/tcjq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjq_ctrl
// command sequencer: scan, add, emit, shift and list steps over the
// datapath, at most one storage access per step
// ----------------------------------------------------------------------------
module tcjq_ctrl import tcjq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_DECODE    = 10'b00_0000_0010,
		S_SCAN_RD   = 10'b00_0000_0100,
		S_SCAN_CMP  = 10'b00_0000_1000,
		S_EMIT_HIT  = 10'b00_0001_0000,
		S_EMIT_MISS = 10'b00_0010_0000,
		S_SHIFT_RD  = 10'b00_0100_0000,
		S_SHIFT_WR  = 10'b00_1000_0000,
		S_LIST_RD   = 10'b01_0000_0000,
		S_LIST_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.mode) inside
					MODE_ADD, MODE_CANCEL: begin
						state_d = S_SCAN_RD;
					end
					MODE_PROCESS: begin
						if (sts.count_zero) begin
							state_d = S_EMIT_MISS;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = RD_FWD;
							state_d    = S_EMIT_HIT;
						end
					end
					MODE_LIST_FWD, MODE_LIST_REV: begin
						state_d = sts.count_zero ? S_EMIT_MISS : S_LIST_RD;
					end
					default: begin
						state_d = S_EMIT_MISS;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (sts.idx_end) begin
					// no match in the queue
					if (sts.mode == MODE_ADD) begin
						ctl.add_write = !sts.full;
						state_d       = S_IDLE;
					end else begin
						state_d = S_EMIT_MISS;
					end
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_FWD;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					// duplicate add is ignored
					state_d = (sts.mode == MODE_ADD) ? S_IDLE : S_EMIT_HIT;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_EMIT_HIT: begin
				if (sts.out_free) begin
					ctl.emit_hit = 1'b1;
					if (sts.idx_zero) begin
						ctl.pop_head = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end
			end
			S_EMIT_MISS: begin
				if (sts.out_free) begin
					ctl.emit_miss = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SHIFT_RD: begin
				if (sts.idx_last) begin
					ctl.count_dec = 1'b1;
					state_d       = S_IDLE;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_NEXT;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				ctl.shift_write = 1'b1;
				ctl.idx_inc     = 1'b1;
				state_d         = S_SHIFT_RD;
			end
			S_LIST_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = (sts.mode == MODE_LIST_REV) ? RD_REV : RD_FWD;
				state_d    = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit_hit      = 1'b1;
					ctl.emit_last_idx = 1'b1;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.idx_inc = 1'b1;
						state_d     = S_LIST_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
